@@ rtl/md5_pkg.sv @@
// md5_pkg: shared types, constants and functions of the md5 message digest block
// holds the round constant, rotation and word index tables used by the round unit
// no dependencies
package md5_pkg;

  typedef logic [31:0] word_t;

  // standard initial chaining values
  localparam word_t IV_A = 32'h67452301;
  localparam word_t IV_B = 32'hEFCDAB89;
  localparam word_t IV_C = 32'h98BADCFE;
  localparam word_t IV_D = 32'h10325476;

  // padding marker byte and length position
  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [3:0] LEN_LO_W  = 4'd14;
  localparam logic [3:0] LEN_HI_W  = 4'd15;
  localparam logic [3:0] LAST_W    = 4'd15;
  localparam logic [5:0] LAST_STEP = 6'd63;
  localparam logic [5:0] LAST_BYTE = 6'd63;

  // top level sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_OUT
  } top_state_t;

  // what the running compression is for
  typedef enum logic [1:0] {
    K_DATA,
    K_EXTRA,
    K_FINAL
  } cmp_kind_t;

  // round unit states
  typedef enum logic [1:0] {
    C_IDLE,
    C_MIX,
    C_RND,
    C_ADD
  } cmp_state_t;

  // block buffer write request
  typedef struct packed {
    logic        en;
    logic [3:0]  idx;
    logic [3:0]  be;
    word_t       data;
  } blk_wr_t;

  // round unit control and status
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cmp_sts_t;

  // byte order swap of one word
  function automatic word_t bswap(input word_t x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

  // left rotate by a variable amount
  function automatic word_t rotl(input word_t x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  // message word index for a step
  function automatic logic [3:0] g_idx(input logic [5:0] step);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = step[3:0];
    case (step[5:4])
      2'd0:    g = i4;
      2'd1:    g = 4'd1 + i4 * 4'd5;
      2'd2:    g = 4'd5 + i4 * 4'd3;
      default: g = i4 * 4'd7;
    endcase
    return g;
  endfunction

  // rotation amount for a step
  function automatic logic [4:0] rot_amt(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'hA: s = 5'd16;
      4'hB: s = 5'd23;
      4'hC: s = 5'd6;
      4'hD: s = 5'd10;
      4'hE: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // round constants
  function automatic word_t k_const(input logic [5:0] step);
    word_t k;
    case (step)
      6'd0:  k = 32'hD76AA478;  6'd1:  k = 32'hE8C7B756;
      6'd2:  k = 32'h242070DB;  6'd3:  k = 32'hC1BDCEEE;
      6'd4:  k = 32'hF57C0FAF;  6'd5:  k = 32'h4787C62A;
      6'd6:  k = 32'hA8304613;  6'd7:  k = 32'hFD469501;
      6'd8:  k = 32'h698098D8;  6'd9:  k = 32'h8B44F7AF;
      6'd10: k = 32'hFFFF5BB1;  6'd11: k = 32'h895CD7BE;
      6'd12: k = 32'h6B901122;  6'd13: k = 32'hFD987193;
      6'd14: k = 32'hA679438E;  6'd15: k = 32'h49B40821;
      6'd16: k = 32'hF61E2562;  6'd17: k = 32'hC040B340;
      6'd18: k = 32'h265E5A51;  6'd19: k = 32'hE9B6C7AA;
      6'd20: k = 32'hD62F105D;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hD8A1E681;  6'd23: k = 32'hE7D3FBC8;
      6'd24: k = 32'h21E1CDE6;  6'd25: k = 32'hC33707D6;
      6'd26: k = 32'hF4D50D87;  6'd27: k = 32'h455A14ED;
      6'd28: k = 32'hA9E3E905;  6'd29: k = 32'hFCEFA3F8;
      6'd30: k = 32'h676F02D9;  6'd31: k = 32'h8D2A4C8A;
      6'd32: k = 32'hFFFA3942;  6'd33: k = 32'h8771F681;
      6'd34: k = 32'h6D9D6122;  6'd35: k = 32'hFDE5380C;
      6'd36: k = 32'hA4BEEA44;  6'd37: k = 32'h4BDECFA9;
      6'd38: k = 32'hF6BB4B60;  6'd39: k = 32'hBEBFBC70;
      6'd40: k = 32'h289B7EC6;  6'd41: k = 32'hEAA127FA;
      6'd42: k = 32'hD4EF3085;  6'd43: k = 32'h04881D05;
      6'd44: k = 32'hD9D4D039;  6'd45: k = 32'hE6DB99E5;
      6'd46: k = 32'h1FA27CF8;  6'd47: k = 32'hC4AC5665;
      6'd48: k = 32'hF4292244;  6'd49: k = 32'h432AFF97;
      6'd50: k = 32'hAB9423A7;  6'd51: k = 32'hFC93A039;
      6'd52: k = 32'h655B59C3;  6'd53: k = 32'h8F0CCC92;
      6'd54: k = 32'hFFEFF47D;  6'd55: k = 32'h85845DD1;
      6'd56: k = 32'h6FA87E4F;  6'd57: k = 32'hFE2CE6E0;
      6'd58: k = 32'hA3014314;  6'd59: k = 32'h4E0811A1;
      6'd60: k = 32'hF7537E82;  6'd61: k = 32'hBD3AF235;
      6'd62: k = 32'h2AD7D2BB;  default: k = 32'hEB86D391;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/md5_blk_buf.sv @@
// md5_blk_buf: sixteen-word message block store with byte-enable writes
// one write port and one read port; uses md5_pkg
module md5_blk_buf
  import md5_pkg::*;
(
  input  logic       clk,
  input  blk_wr_t    wr,
  input  logic [3:0] rd_idx,
  output word_t      rd_word
);

  word_t words_r [16];

  // byte-enable write, no reset: every lane is written before it is read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      for (int j = 0; j < 4; j++) begin
        if (wr.be[j]) begin
          words_r[wr.idx][j*8 +: 8] <= wr.data[j*8 +: 8];
        end
      end
    end
  end

  // word select for the round unit
  assign rd_word = words_r[rd_idx];

endmodule

@@ rtl/md5_compress.sv @@
// md5_compress: chaining words and the shared round unit, a mix state and a round state per step
// 64 steps then a chaining add; uses md5_pkg
module md5_compress
  import md5_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  cmp_ctl_t        ctl,
  input  word_t           rd_word,
  output logic [3:0]      rd_idx,
  output cmp_sts_t        sts,
  output logic [3:0][31:0] chain
);

  cmp_state_t       state_r, state_nxt;
  logic [5:0]       step_r, step_nxt;
  word_t            a_r, b_r, c_r, d_r, tmp_r;
  word_t            a_nxt, b_nxt, c_nxt, d_nxt, tmp_nxt;
  logic [3:0][31:0] chain_r, chain_nxt;
  word_t            f_val, t_val;

  // state and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      step_r  <= '0;
      chain_r <= {IV_D, IV_C, IV_B, IV_A};
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      chain_r <= chain_nxt;
    end
  end

  // working variables
  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    c_r   <= c_nxt;
    d_r   <= d_nxt;
    tmp_r <= tmp_nxt;
  end

  // round boolean function
  always_comb begin
    case (step_r[5:4])
      2'd0:    f_val = (b_r & c_r) | (~b_r & d_r);
      2'd1:    f_val = (b_r & d_r) | (c_r & ~d_r);
      2'd2:    f_val = b_r ^ c_r ^ d_r;
      default: f_val = c_r ^ (b_r | ~d_r);
    endcase
  end

  assign t_val = tmp_r + f_val;

  // sequencer for steps and the final add
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    chain_nxt = chain_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    tmp_nxt   = tmp_r;
    case (state_r)
      C_IDLE: begin
        if (ctl.init) begin
          chain_nxt = {IV_D, IV_C, IV_B, IV_A};
        end
        if (ctl.start) begin
          a_nxt     = chain_r[0];
          b_nxt     = chain_r[1];
          c_nxt     = chain_r[2];
          d_nxt     = chain_r[3];
          step_nxt  = '0;
          state_nxt = C_MIX;
        end
      end
      C_MIX: begin
        tmp_nxt   = a_r + k_const(step_r) + rd_word;
        state_nxt = C_RND;
      end
      C_RND: begin
        a_nxt    = d_r;
        d_nxt    = c_r;
        c_nxt    = b_r;
        b_nxt    = b_r + rotl(t_val, rot_amt(step_r));
        step_nxt = 6'(step_r + 6'd1);
        if (step_r == LAST_STEP) begin
          state_nxt = C_ADD;
        end else begin
          state_nxt = C_MIX;
        end
      end
      C_ADD: begin
        chain_nxt[0] = chain_r[0] + a_r;
        chain_nxt[1] = chain_r[1] + b_r;
        chain_nxt[2] = chain_r[2] + c_r;
        chain_nxt[3] = chain_r[3] + d_r;
        state_nxt    = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  assign rd_idx   = g_idx(step_r);
  assign sts.busy = (state_r != C_IDLE);
  assign sts.done = (state_r == C_ADD);
  assign chain    = chain_r;

endmodule

@@ rtl/md5_message_digest_top.sv @@
// md5_message_digest_top: byte-serial md5 digest with padding and length append
// uses md5_pkg, md5_blk_buf and md5_compress
//
// Input channel in_*: one item per message byte. in_tdata carries the byte,
// in_tuser[0] says the byte is present, in_tlast ends the message. An item with
// neither present nor last changes nothing; a bare last item gives the digest
// of what came before (the empty message when alone).
// Output channel out_*: one item per message, the four chaining words each
// byte-swapped, word 0 in the lowest bits of out_tdata.
// Intake: in_tready is high only in the idle state, so a byte that does not fill
// a block is taken without a stall. The 64th byte of a block starts the round
// unit, which runs its 64 steps and the chaining add before in_tready returns.
// End of message: up to 16 padding word writes, then a round run; one more padding
// pass and round run when 8 bytes of room or fewer remain; then the digest register
// is loaded from the byte-swapped chaining words.
// The digest waits in an output register; the block then restarts and takes
// the next message at once, stalling only if a second digest is due while
// the first is still untaken. Reset clears the chaining words to the md5
// initial values and the byte count to zero; no clearing pass is needed.
module md5_message_digest_top
  import md5_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte [7:0]
  input  logic [0:0]   in_tuser,   // byte_present [0]
  input  logic         in_tlast,   // last_of_message
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata   // digest_word_0 [31:0], _1 [63:32], _2 [95:64], _3 [127:96]
);

  top_state_t       state_r, state_nxt;
  cmp_kind_t        kind_r, kind_nxt;
  logic [60:0]      cnt_r, cnt_nxt;
  logic             last_r, last_nxt;
  logic             fresh_r, fresh_nxt;
  logic [3:0]       w_r, w_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [127:0]     out_data_r, out_data_nxt;
  logic             in_acc;
  blk_wr_t          wr;
  blk_wr_t          pad_wr;
  cmp_ctl_t         ctl;
  cmp_sts_t         sts;
  logic [3:0]       rd_idx;
  word_t            rd_word;
  logic [3:0][31:0] chain;
  logic [63:0]      bit_len;
  logic [5:0]       off;
  logic [5:0]       pos;

  md5_blk_buf u_buf (
    .clk     (clk),
    .wr      (wr),
    .rd_idx  (rd_idx),
    .rd_word (rd_word)
  );

  md5_compress u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .rd_word (rd_word),
    .rd_idx  (rd_idx),
    .sts     (sts),
    .chain   (chain)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign bit_len    = {cnt_r, 3'b000};
  assign off        = cnt_r[5:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kind_r      <= K_DATA;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      fresh_r     <= 1'b0;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      fresh_r     <= fresh_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // digest register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  // padding word: marker, zeros or length, bytes before the end untouched
  always_comb begin
    pad_wr.en  = 1'b1;
    pad_wr.idx = w_r;
    pad_wr.be  = 4'hF;
    pad_wr.data = '0;
    pos = '0;
    if (fresh_r || (w_r >= LEN_LO_W && off < LEN_START)) begin
      if (w_r == LEN_LO_W) begin
        pad_wr.data = bit_len[31:0];
      end else if (w_r == LEN_HI_W) begin
        pad_wr.data = bit_len[63:32];
      end
    end else begin
      for (int j = 0; j < 4; j++) begin
        pos = {w_r, 2'(j)};
        pad_wr.be[j] = (pos >= off);
        pad_wr.data[j*8 +: 8] = (pos == off) ? PAD_BYTE : 8'h00;
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    fresh_nxt     = fresh_r;
    w_nxt         = w_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr            = '0;
    ctl           = '0;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser[0]) begin
            wr.en   = 1'b1;
            wr.idx  = cnt_r[5:2];
            wr.be   = 4'b0001 << cnt_r[1:0];
            wr.data = {4{in_tdata}};
            cnt_nxt = 61'(cnt_r + 61'd1);
            if (cnt_r[5:0] == LAST_BYTE) begin
              ctl.start = 1'b1;
              kind_nxt  = K_DATA;
              last_nxt  = in_tlast;
              state_nxt = S_COMP;
            end else if (in_tlast) begin
              w_nxt     = cnt_nxt[5:2];
              fresh_nxt = 1'b0;
              state_nxt = S_PAD;
            end
          end else if (in_tlast) begin
            w_nxt     = cnt_r[5:2];
            fresh_nxt = 1'b0;
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        wr    = pad_wr;
        w_nxt = 4'(w_r + 4'd1);
        if (w_r == LAST_W) begin
          ctl.start = 1'b1;
          if (!fresh_r && off >= LEN_START) begin
            kind_nxt = K_EXTRA;
          end else begin
            kind_nxt = K_FINAL;
          end
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          case (kind_r)
            K_DATA: begin
              if (last_r) begin
                w_nxt     = '0;
                fresh_nxt = 1'b0;
                state_nxt = S_PAD;
              end else begin
                state_nxt = S_IDLE;
              end
            end
            K_EXTRA: begin
              w_nxt     = '0;
              fresh_nxt = 1'b1;
              state_nxt = S_PAD;
            end
            K_FINAL: state_nxt = S_OUT;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {bswap(chain[3]), bswap(chain[2]),
                           bswap(chain[1]), bswap(chain[0])};
          out_valid_nxt = 1'b1;
          ctl.init      = 1'b1;
          cnt_nxt       = '0;
          last_nxt      = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // the round unit runs only while no item is taken
  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    sts.busy |-> !in_tready)
    else $error("item accepted while round unit busy");

  // a byte completing a block starts a compression
  a_full_block_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser[0] && cnt_r[5:0] == LAST_BYTE) |=> (state_r == S_COMP && sts.busy))
    else $error("full block did not start compression");

  // a new digest never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> $stable(out_data_r))
    else $error("pending digest overwritten");

  // the round unit finishes only while the sequencer waits for it
  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    sts.done |-> (state_r == S_COMP))
    else $error("compression finished outside wait state");

endmodule

@@ tb/sv/testbench.sv @@
// testbench for md5_message_digest_top: byte streams in, one digest item per message out
// a byte-level md5 tracker in the bench predicts each digest not typed in; random gaps on both sides
// depends on md5_pkg and md5_message_digest_top
module testbench;
  import md5_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RAND_BYTES = 1450;
  localparam int DIR_ROWS = 14;

  // md5 sine-derived additive constants, one per step
  localparam logic [31:0] ROUND_K [64] = '{
    32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
    32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
    32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
    32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
    32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
    32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
    32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
    32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
    32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
    32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
    32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
    32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
    32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
    32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
    32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
    32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391
  };

  // rotate amounts, indexed by round and step within a group of four
  localparam int SHIFT_TAB [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                    4, 11, 16, 23, 6, 10, 15, 21};

  // digests that can be read off directly
  localparam logic [127:0] DIG_EMPTY = {32'hECF8427E, 32'hE9800998, 32'h8F00B204, 32'hD41D8CD9};
  localparam logic [127:0] DIG_A     = {32'h69772661, 32'h31C399E2, 32'hC0F1B6A8, 32'h0CC175B9};
  localparam logic [127:0] DIG_ABC   = {32'h28E17F72, 32'hD6963F7D, 32'h3CD24FB0, 32'h90015098};

  typedef struct packed {
    logic [7:0]   data;
    logic         present;
    logic         fin;
    logic         known;
    logic [127:0] digest;
  } stim_row_t;

  // directed items: known digests typed in, the rest go through the tracker
  localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DIG_EMPTY},   // bare end marker alone
    '{8'hFF, 1'b0, 1'b0, 1'b0, '0},          // idle item
    '{8'h61, 1'b1, 1'b1, 1'b1, DIG_A},       // byte with end marker
    '{8'h61, 1'b1, 1'b0, 1'b0, '0},
    '{8'h62, 1'b1, 1'b0, 1'b0, '0},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIG_ABC},
    '{8'h00, 1'b0, 1'b0, 1'b0, '0},          // idle item, low data
    '{8'h00, 1'b1, 1'b0, 1'b0, '0},
    '{8'hFF, 1'b1, 1'b0, 1'b0, '0},
    '{8'h80, 1'b1, 1'b0, 1'b0, '0},
    '{8'h7F, 1'b0, 1'b1, 1'b0, '0},          // bare end marker after bytes
    '{8'hFF, 1'b1, 1'b1, 1'b0, '0},
    '{8'h55, 1'b0, 1'b0, 1'b0, '0},
    '{8'hAA, 1'b0, 1'b1, 1'b1, DIG_EMPTY}    // ignored data on a bare end
  };

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // data_byte [7:0]
  logic [0:0]   in_tuser;   // byte_present [0]
  logic         in_tlast;   // last_of_message
  logic         out_tvalid;
  logic         out_tready;
  logic [127:0] out_tdata;  // digest_word_0 [31:0], _1 [63:32], _2 [95:64], _3 [127:96]

  // tracker state
  logic [31:0]  chain_w [4];
  logic [31:0]  blk_w [16];
  logic [60:0]  msg_bytes;

  logic [127:0] pending_digests [$];
  int           fails;
  int           cycle_cnt;
  int           bytes_taken;
  logic         calm;

  md5_message_digest_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // back to the start of a message
  task automatic md5_restart();
    chain_w[0] = IV_A;
    chain_w[1] = IV_B;
    chain_w[2] = IV_C;
    chain_w[3] = IV_D;
    foreach (blk_w[i]) blk_w[i] = '0;
    msg_bytes = '0;
  endtask

  // 64 steps over the current block, folded into the chaining words
  task automatic md5_compress_block();
    logic [31:0] va, vb, vc, vd, f, t;
    int g, s;
    va = chain_w[0];
    vb = chain_w[1];
    vc = chain_w[2];
    vd = chain_w[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (vb & vc) | (~vb & vd);
          g = i;
        end
        1: begin
          f = (vb & vd) | (vc & ~vd);
          g = (1 + 5 * i) % 16;
        end
        2: begin
          f = vb ^ vc ^ vd;
          g = (5 + 3 * i) % 16;
        end
        default: begin
          f = vc ^ (vb | ~vd);
          g = (7 * i) % 16;
        end
      endcase
      t = va + f + ROUND_K[i] + blk_w[g];
      s = SHIFT_TAB[(i / 16) * 4 + i % 4];
      va = vd;
      vd = vc;
      vc = vb;
      vb = vb + ((t << s) | (t >> (32 - s)));
    end
    chain_w[0] = chain_w[0] + va;
    chain_w[1] = chain_w[1] + vb;
    chain_w[2] = chain_w[2] + vc;
    chain_w[3] = chain_w[3] + vd;
  endtask

  // absorb one accepted item; on an end marker pad, finish and give the digest
  task automatic md5_track(input logic [7:0] b, input logic pres, input logic fin,
                           output logic got, output logic [127:0] dig);
    int off;
    logic [63:0] nbits;
    logic [31:0] w;
    got = 1'b0;
    dig = '0;
    if (pres) begin
      blk_w[msg_bytes[5:2]][msg_bytes[1:0] * 8 +: 8] = b;
      msg_bytes = msg_bytes + 61'd1;
      if (msg_bytes[5:0] == 6'd0) md5_compress_block();
    end
    if (fin) begin
      off = msg_bytes[5:0];
      blk_w[off / 4][(off % 4) * 8 +: 8] = PAD_BYTE;
      for (int p = off + 1; p < 64; p++) blk_w[p / 4][(p % 4) * 8 +: 8] = 8'h00;
      // no room for the length: spill into an extra block
      if (off >= LEN_START) begin
        md5_compress_block();
        foreach (blk_w[i]) blk_w[i] = '0;
      end
      nbits = {msg_bytes, 3'b000};
      blk_w[14] = nbits[31:0];
      blk_w[15] = nbits[63:32];
      md5_compress_block();
      for (int k = 0; k < 4; k++) begin
        w = chain_w[k];
        dig[32 * k +: 32] = {w[7:0], w[15:8], w[23:16], w[31:24]};
      end
      got = 1'b1;
      md5_restart();
    end
  endtask

  // present one item, with random gaps, and track it once it is taken
  task automatic send_item(input logic [7:0] b, input logic pres, input logic fin,
                           input logic known, input logic [127:0] kdig);
    logic got;
    logic [127:0] dig;
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= pres;
    in_tlast  <= fin;
    do @(posedge clk); while (in_tready !== 1'b1);
    md5_track(b, pres, fin, got, dig);
    if (got) pending_digests.push_back(known ? kdig : dig);
    if (pres) bytes_taken++;
    calm = (bytes_taken >= 600) && (bytes_taken < 900);
  endtask

  // one random message: mostly short, often near block edges, a few long
  task automatic send_message();
    int r, len;
    logic end_on_byte;
    r = $urandom_range(0, 99);
    if (r < 40) len = $urandom_range(0, 20);
    else if (r < 70) len = 64 * $urandom_range(0, 1) + $urandom_range(54, 65);
    else if (r < 95) len = $urandom_range(0, 140);
    else len = $urandom_range(141, 300);
    end_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      // stray idle items inside the message
      if ($urandom_range(0, 99) < 8) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
      send_item(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1), 1'b0, '0);
    end
    if (!end_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // result side: random stalls, compare each digest word with the oldest expectation
  always @(posedge clk) begin
    logic [127:0] want;
    if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (pending_digests.size() == 0) begin
        $display("%0t: unexpected digest item %h", $time, out_tdata);
        fails++;
      end else begin
        want = pending_digests.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (out_tdata[32 * k +: 32] !== want[32 * k +: 32]) begin
            $display("%0t: digest_word_%0d expected %h actual %h", $time, k,
                     want[32 * k +: 32], out_tdata[32 * k +: 32]);
            fails++;
          end
        end
      end
    end
    out_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 20);
  end

  // stimulus
  initial begin
    fails = 0;
    bytes_taken = 0;
    calm = 1'b0;
    md5_restart();
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= '0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    for (int i = 0; i < DIR_ROWS; i++)
      send_item(DIR_TAB[i].data, DIR_TAB[i].present, DIR_TAB[i].fin,
                DIR_TAB[i].known, DIR_TAB[i].digest);

    // random messages
    bytes_taken = 0;
    while (bytes_taken < RAND_BYTES) send_message();
    in_tvalid <= 1'b0;

    // drain, then let any stray item show
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
